[rtl/rsd_pkg.sv]
package rsd_pkg;

	// One raw register snapshot as it arrives on the input queue.
	typedef struct packed {
		logic [7:0] raw_sec;
		logic [7:0] raw_min;
		logic [7:0] raw_hour;
		logic [7:0] raw_day;
		logic [7:0] raw_month;
		logic [7:0] raw_year;
		logic [7:0] raw_century;
		logic       uip_timeout;
	} snapshot_t;

	// One decoded result word.
	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
		logic [33:0] unix_seconds;
	} result_t;

	// The clock register bytes (century down to second) compared between the first and second read of a pair.
	typedef struct packed {
		logic [7:0] century;
		logic [7:0] year;
		logic [7:0] month;
		logic [7:0] day;
		logic [7:0] hour;
		logic [7:0] minute;
		logic [7:0] second;
	} raw_regs_t;

	// Work handed from the front to the back; kind uses the status codes.
	typedef struct packed {
		logic [1:0] kind;
		logic       binary_mode;
		logic       hour24_mode;
		raw_regs_t  regs;
	} job_t;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_UIP_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_NO_AGREE    = 2'd2;
	localparam logic [1:0] ST_IMPLAUSIBLE = 2'd3;

	localparam logic REG_BINARY_MODE = 1'b0;
	localparam logic REG_HOUR24_MODE = 1'b1;

	localparam int OUT_DEPTH   = 8;

	function automatic logic [7:0] field_value(input logic [7:0] v, input logic bin);
		logic [7:0] bcd;
		bcd = 8'(v[3:0]) + 8'(v[7:4]) * 8'd10;
		return bin ? v : bcd;
	endfunction

	// Day of year of the first of each month, counted from March 1.
	function automatic logic [8:0] month_offset(input logic [7:0] mon);
		logic [8:0] r;
		case (mon)
			8'd3:    r = 9'd0;
			8'd4:    r = 9'd31;
			8'd5:    r = 9'd61;
			8'd6:    r = 9'd92;
			8'd7:    r = 9'd122;
			8'd8:    r = 9'd153;
			8'd9:    r = 9'd184;
			8'd10:   r = 9'd214;
			8'd11:   r = 9'd245;
			8'd12:   r = 9'd275;
			8'd1:    r = 9'd306;
			8'd2:    r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/rsd_fifo.sv]
module rsd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/rsd_front.sv]
module rsd_front
	import rsd_pkg::*;
#(
	parameter int MAX_TRIES = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  snapshot_t snap,
	input  logic      binary_mode,
	input  logic      hour24_mode,
	output logic      job_valid,
	output job_t      job
);

	localparam int CW = $clog2(MAX_TRIES + 1);

	raw_regs_t     first_q;
	logic          have_first_q;
	logic [CW-1:0] attempt_q;
	raw_regs_t     cur;
	logic          match;
	logic [CW-1:0] next_cnt;
	logic          last_try;

	assign cur = '{century: snap.raw_century, year: snap.raw_year,
		month: snap.raw_month, day: snap.raw_day, hour: snap.raw_hour,
		minute: snap.raw_min, second: snap.raw_sec};
	assign match    = (cur == first_q);
	assign next_cnt = attempt_q + 1'b1;
	assign last_try = (next_cnt == CW'(MAX_TRIES));

	always_comb begin
		job.binary_mode = binary_mode;
		job.hour24_mode = hour24_mode;
		job.regs        = first_q;
		job.kind        = ST_OK;
		job_valid       = 1'b0;
		if (accept) begin
			if (snap.uip_timeout) begin
				job.kind  = ST_UIP_TIMEOUT;
				job_valid = 1'b1;
			end else if (have_first_q) begin
				if (match) begin
					job_valid = 1'b1;
				end else if (last_try) begin
					job.kind  = ST_NO_AGREE;
					job_valid = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q      <= '0;
			have_first_q <= 1'b0;
			attempt_q    <= '0;
		end else if (accept) begin
			if (snap.uip_timeout) begin
				have_first_q <= 1'b0;
				attempt_q    <= '0;
			end else if (!have_first_q) begin
				first_q      <= cur;
				have_first_q <= 1'b1;
			end else begin
				have_first_q <= 1'b0;
				if (match || last_try) begin
					attempt_q <= '0;
				end else begin
					attempt_q <= next_cnt;
				end
			end
		end
	end

endmodule

[rtl/rsd_back.sv]
module rsd_back
	import rsd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_avail,
	input  job_t    job,
	output logic    job_take,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	localparam int RW = $clog2(OUT_DEPTH + 1);

	logic [RW-1:0] reserved_q;
	logic          out_pop;
	logic          out_full;

	// s1: field decode and checks
	logic [7:0]  sec, mnt, day, mon, yr, cent_raw, hr0, hr12, hr;
	logic [4:0]  cent;
	logic [11:0] year;
	logic        bad;
	result_t     res_c;
	logic        ok_c;

	logic          valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	result_t       res_s1, res_s2, res_s3, res_s4, res_s5;
	logic          ok_s1, ok_s2, ok_s3, ok_s4;
	logic [11:0]   yadj_s1;
	logic [9:0]    doyd_s1, doyd_s2;
	logic [19:0]   y365_s2;
	logic [5:0]    q100_s2;
	logic [9:0]    y4_s2;
	logic [24:0]   q100_prod;
	logic signed [21:0] days_s3;
	logic [18:0]   tsec_s3, tsec_s4;
	logic signed [36:0] tday_s4;
	logic signed [36:0] t_sum;
	result_t       res_fin;

	assign out_pop  = pop && !empty;
	assign job_take = job_avail && (reserved_q < RW'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
		end else if (job_take && !out_pop) begin
			reserved_q <= reserved_q + 1'b1;
		end else if (out_pop && !job_take) begin
			reserved_q <= reserved_q - 1'b1;
		end
	end

	always_comb begin
		sec      = field_value(job.regs.second, job.binary_mode);
		mnt      = field_value(job.regs.minute, job.binary_mode);
		day      = field_value(job.regs.day, job.binary_mode);
		mon      = field_value(job.regs.month, job.binary_mode);
		yr       = field_value(job.regs.year, job.binary_mode);
		cent_raw = field_value(job.regs.century, job.binary_mode);
		hr0      = field_value({1'b0, job.regs.hour[6:0]}, job.binary_mode);
		hr12     = (hr0 == 8'd12) ? 8'd0 : hr0;
		if (job.hour24_mode) begin
			hr = hr0;
		end else begin
			hr = job.regs.hour[7] ? hr12 + 8'd12 : hr12;
		end
		cent = (cent_raw < 8'd19 || cent_raw > 8'd21) ? 5'd20 : cent_raw[4:0];
		year = 12'(cent) * 12'd100 + 12'(yr);
		bad  = mon < 8'd1 || mon > 8'd12 || day < 8'd1 || day > 8'd31 ||
			hr > 8'd23 || mnt > 8'd59 || sec > 8'd60;

		res_c = '0;
		ok_c  = 1'b0;
		if (job.kind == ST_OK) begin
			res_c.status = bad ? ST_IMPLAUSIBLE : ST_OK;
			res_c.year   = year;
			res_c.month  = mon;
			res_c.day    = day;
			res_c.hour   = hr;
			res_c.minute = mnt;
			res_c.second = sec;
			ok_c         = !bad;
		end else begin
			res_c.status = job.kind;
		end
	end

	assign q100_prod = 25'(yadj_s1) * 25'd5243;
	assign t_sum     = tday_s4 + 37'(tsec_s4);

	// s5 word: epoch seconds only for a plausible date after the epoch
	always_comb begin
		res_fin              = res_s4;
		res_fin.unix_seconds = (ok_s4 && !t_sum[36] && t_sum != '0) ? t_sum[33:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= job_take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		// s1
		res_s1  <= res_c;
		ok_s1   <= ok_c;
		yadj_s1 <= (mon <= 8'd2) ? year - 12'd1 : year;
		doyd_s1 <= 10'(month_offset(mon)) + 10'(day) - 10'd1;
		// s2: year terms, y/100 by reciprocal (exact for these years)
		res_s2  <= res_s1;
		ok_s2   <= ok_s1;
		doyd_s2 <= doyd_s1;
		y365_s2 <= 20'(yadj_s1) * 20'd365;
		q100_s2 <= q100_prod[24:19];
		y4_s2   <= yadj_s1[11:2];
		// s3: days since epoch, seconds within the day
		res_s3  <= res_s2;
		ok_s3   <= ok_s2;
		days_s3 <= 22'(y365_s2) + 22'(y4_s2) - 22'(q100_s2) + 22'(q100_s2[5:2])
			+ 22'(doyd_s2) - 22'(719468);
		tsec_s3 <= 19'(res_s2.hour) * 19'd3600 + 19'(res_s2.minute) * 19'd60
			+ 19'(res_s2.second);
		// s4
		res_s4  <= res_s3;
		ok_s4   <= ok_s3;
		tday_s4 <= 37'(days_s3) * 37'sd86400;
		tsec_s4 <= tsec_s3;
		// s5
		res_s5  <= res_fin;
	end

	// Credit count keeps this queue from overflowing; full is never seen high on push.
	rsd_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (valid_s5),
		.wr_data (res_s5),
		.pop     (pop),
		.rd_data (result),
		.full    (out_full),
		.empty   (empty)
	);

	logic unused_full;
	assign unused_full = out_full;

endmodule

[rtl/rtc_snapshot_time_decoder.sv]
// Clock register snapshot decoder.
// Input queue: push/full with one snapshot word; a word is taken on a clock
// edge with push high and full low. Snapshots come in pairs; the first is
// held, the second is compared with it. A match decodes the time, MAX_TRIES
// failed pairs give a "never agreed" word, and a snapshot flagged with a UIP
// timeout gives a timeout word at once and restarts the pairing.
// Result queue: empty/pop; the oldest result word sits on result while empty
// is low and leaves on an edge with pop high.
// Config: cfg_valid/cfg_ready (ready always high), cfg_index selects
// binary_mode (0) or hour24_mode (1). Write only while the block is idle.
// Path: an accepted snapshot's job is written into the job queue, then
// passes five decode stages (s1 to s5) into the result queue.
// Throughput: one snapshot per cycle while full is low; the front compare is combinational.
// If the reader stalls, the result queue (8 words, credit counted) and the
// job queue fill, then full rises; nothing is dropped.
// Reset clears the pairing state and both queues; binary_mode resets to 0,
// hour24_mode to 1.
module rtc_snapshot_time_decoder
	import rsd_pkg::*;
#(
	parameter int MAX_TRIES   = 8,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  snapshot_t snapshot,
	output logic      empty,
	input  logic      pop,
	output result_t   result,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_index,
	input  logic      cfg_data
);

	logic binary_mode_q;
	logic hour24_mode_q;
	logic accept;
	logic job_valid;
	job_t job_in;
	job_t job_out;
	logic job_empty;
	logic job_take;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			binary_mode_q <= 1'b0;
			hour24_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BINARY_MODE: binary_mode_q <= cfg_data;
				REG_HOUR24_MODE: hour24_mode_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: pairing, compare, retry count
	rsd_front #(
		.MAX_TRIES(MAX_TRIES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.snap        (snapshot),
		.binary_mode (binary_mode_q),
		.hour24_mode (hour24_mode_q),
		.job_valid   (job_valid),
		.job         (job_in)
	);

	// job queue between front and back; full here stalls the input side
	rsd_fifo #(
		.WIDTH($bits(job_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_valid),
		.wr_data (job_in),
		.pop     (job_take),
		.rd_data (job_out),
		.full    (full),
		.empty   (job_empty)
	);

	// back: field decode, range check, epoch seconds, result queue
	rsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (!job_empty),
		.job       (job_out),
		.job_take  (job_take),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

[rtl/rsd_checker.sv]
module rsd_checker
	import rsd_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      empty,
	input logic      pop,
	input result_t   result
);

	// a waiting word holds while the reader stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result word changed while stalled");

	// failure words carry nothing but the status
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result.status == ST_UIP_TIMEOUT || result.status == ST_NO_AGREE) |->
		result.year == '0 && result.month == '0 && result.day == '0 &&
		result.hour == '0 && result.minute == '0 && result.second == '0 &&
		result.unix_seconds == '0)
		else $error("failure word with nonzero fields");

	// an ok word lies in range
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status == ST_OK |->
		result.month >= 8'd1 && result.month <= 8'd12 && result.day >= 8'd1 &&
		result.day <= 8'd31 && result.hour <= 8'd23 && result.minute <= 8'd59 &&
		result.second <= 8'd60 && result.year >= 12'd1900)
		else $error("ok word out of range");

	// implausible words give no epoch seconds
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status == ST_IMPLAUSIBLE |-> result.unix_seconds == '0)
		else $error("implausible word with epoch seconds");

endmodule

bind rtc_snapshot_time_decoder rsd_checker u_rsd_checker (.*);

[test/rtc_snapshot_time_decoder_tb.sv]
module rtc_snapshot_time_decoder_tb;
	import rsd_pkg::*;

	localparam int PAIR_RETRIES = 8;       // matches the block's MAX_TRIES default
	localparam int DRAIN_CYCLES = 16;      // longer than the accept-to-result path
	localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run
	localparam int SHOW_LIMIT   = 10;

	// receiver pop patterns
	typedef enum {READ_ALWAYS, READ_MOSTLY, READ_SPARSE, READ_PERIODIC} read_mode_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	snapshot_t snapshot = '0;
	logic      empty;
	logic      pop = 1'b0;
	result_t   result;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_index = 1'b0;
	logic      cfg_data = 1'b0;

	rtc_snapshot_time_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.snapshot (snapshot),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Decoder mirror: config, pairing state and the queue of due words
	// ------------------------------------------------------------------
	bit        bin_mode = 1'b0;
	bit        h24_mode = 1'b1;
	raw_regs_t held_regs = '0;
	bit        holding_first = 1'b0;
	int        failed_pairs = 0;
	result_t   decoded_due[$];

	// bookkeeping for the checker and the summary
	int cycle_count = 0;
	int words_checked = 0;
	int bad_words = 0;
	int items_sent = 0;
	int full_stalls = 0;
	int status_tally[4] = '{0, 0, 0, 0};
	int mode_phases = 0;

	// sender pacing
	bit pacing_on = 1'b1;
	int burst_left = 0;

	// receiver control; hold_request is a one-shot long hold in cycles
	int         hold_request = 0;
	int         hold_left = 0;
	int         mode_left = 0;
	int         periodic_tick = 0;
	read_mode_t read_mode = READ_ALWAYS;

	// Raw register byte to number: binary mode passes it through; BCD is low + 10 * high, nibbles unchecked.
	function automatic int as_number(logic [7:0] v);
		if (bin_mode)
			return int'(v);
		return int'(v[3:0]) + 10 * int'(v[7:4]);
	endfunction

	// Days from 1970-01-01, March-based year so the leap day falls last.
	function automatic longint epoch_days(longint y, longint m, longint d);
		longint era, yoe, doy, doe;
		if (m <= 2)
			y = y - 1;
		era = y / 400;
		yoe = y - era * 400;
		doy = (153 * (m + ((m > 2) ? -3 : 9)) + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468;
	endfunction

	function automatic result_t decode_time(raw_regs_t r);
		int      sec_v, min_v, hr_v, day_v, mon_v, yr_v, cent_v;
		bit      pm, implausible;
		longint  t;
		result_t w;
		sec_v = as_number(r.second);
		min_v = as_number(r.minute);
		day_v = as_number(r.day);
		mon_v = as_number(r.month);
		yr_v = as_number(r.year);
		cent_v = as_number(r.century);
		pm = !h24_mode && r.hour[7];
		hr_v = as_number({1'b0, r.hour[6:0]});
		if (!h24_mode) begin
			if (hr_v == 12)
				hr_v = 0;
			if (pm)
				hr_v += 12;
		end
		// absent or odd century register reads as 20xx
		if (cent_v < 19 || cent_v > 21)
			cent_v = 20;
		implausible = mon_v < 1 || mon_v > 12 || day_v < 1 || day_v > 31 ||
			hr_v > 23 || min_v > 59 || sec_v > 60;
		w = '0;
		w.status = implausible ? ST_IMPLAUSIBLE : ST_OK;
		w.year = 12'(cent_v * 100 + yr_v);
		w.month = 8'(mon_v);
		w.day = 8'(day_v);
		w.hour = 8'(hr_v);
		w.minute = 8'(min_v);
		w.second = 8'(sec_v);
		if (!implausible) begin
			// day past month end just rolls on arithmetically
			t = epoch_days(cent_v * 100 + yr_v, mon_v, day_v) * 86400 +
				longint'(hr_v) * 3600 + longint'(min_v) * 60 + longint'(sec_v);
			if (t > 0)
				w.unix_seconds = t[33:0];
		end
		return w;
	endfunction

	function automatic result_t status_only(logic [1:0] st);
		result_t w;
		w = '0;
		w.status = st;
		return w;
	endfunction

	// Advance the mirror by one accepted snapshot.
	task automatic predict_decode(snapshot_t s);
		raw_regs_t r;
		r = {s.raw_century, s.raw_year, s.raw_month, s.raw_day,
			s.raw_hour, s.raw_min, s.raw_sec};
		if (s.uip_timeout) begin
			// timeout drops the snapshot in either slot and restarts pairing
			holding_first = 1'b0;
			failed_pairs = 0;
			decoded_due.push_back(status_only(ST_UIP_TIMEOUT));
		end else if (!holding_first) begin
			held_regs = r;
			holding_first = 1'b1;
		end else begin
			holding_first = 1'b0;
			if (r == held_regs) begin
				failed_pairs = 0;
				decoded_due.push_back(decode_time(held_regs));
			end else begin
				failed_pairs++;
				if (failed_pairs >= PAIR_RETRIES) begin
					failed_pairs = 0;
					decoded_due.push_back(status_only(ST_NO_AGREE));
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Clock-edge processes: cycle limit, receiver, checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d words still due",
				cycle_count, decoded_due.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: picks a pop pattern for a random stretch; a long hold
	// request overrides the pattern for a counted number of cycles.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				case ($urandom_range(0, 3))
					0: read_mode = READ_ALWAYS;
					1: read_mode = READ_MOSTLY;
					2: read_mode = READ_SPARSE;
					default: read_mode = READ_PERIODIC;
				endcase
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			periodic_tick = (periodic_tick + 1) % 5;
			case (read_mode)
				READ_ALWAYS: pop <= 1'b1;
				READ_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
				READ_SPARSE: pop <= ($urandom_range(0, 3) == 0);
				default:     pop <= (periodic_tick < 2);
			endcase
		end
	end

	// Checker: a word leaves at an edge with pop high and empty low.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			words_checked++;
			status_tally[result.status]++;
			if (decoded_due.size() == 0) begin
				bad_words++;
				if (bad_words <= SHOW_LIMIT)
					$display("cycle %0d: word with no decode due, status %0d",
						cycle_count, result.status);
			end else begin
				want = decoded_due.pop_front();
				if (result.status !== want.status || result.year !== want.year ||
					result.month !== want.month || result.day !== want.day ||
					result.hour !== want.hour || result.minute !== want.minute ||
					result.second !== want.second ||
					result.unix_seconds !== want.unix_seconds) begin
					bad_words++;
					if (bad_words <= SHOW_LIMIT) begin
						$display("cycle %0d: want st %0d %0d-%0d-%0d %0d:%0d:%0d unix %0d",
							cycle_count, want.status, want.year, want.month, want.day,
							want.hour, want.minute, want.second, want.unix_seconds);
						$display("          got  st %0d %0d-%0d-%0d %0d:%0d:%0d unix %0d",
							result.status, result.year, result.month, result.day,
							result.hour, result.minute, result.second,
							result.unix_seconds);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	function automatic snapshot_t snap_of(raw_regs_t r, bit uip);
		snapshot_t s;
		s.raw_sec = r.second;
		s.raw_min = r.minute;
		s.raw_hour = r.hour;
		s.raw_day = r.day;
		s.raw_month = r.month;
		s.raw_year = r.year;
		s.raw_century = r.century;
		s.uip_timeout = uip;
		return s;
	endfunction

	// Register image in seconds-first argument order.
	function automatic raw_regs_t regs(logic [7:0] sec, logic [7:0] min,
		logic [7:0] hr, logic [7:0] day, logic [7:0] mon, logic [7:0] yr,
		logic [7:0] cent);
		return {cent, yr, mon, day, hr, min, sec};
	endfunction

	// Number to register byte in the current encoding.
	function automatic logic [7:0] encode(int v);
		if (bin_mode)
			return 8'(v);
		return {4'(v / 10), 4'(v % 10)};
	endfunction

	// Mostly sane clock contents, with a random byte dropped in now and then.
	function automatic raw_regs_t random_regs();
		raw_regs_t r;
		int        hr, h12, k;
		hr = $urandom_range(0, 23);
		r.second = encode($urandom_range(0, 60));
		r.minute = encode($urandom_range(0, 59));
		r.day = encode($urandom_range(1, 31));
		r.month = encode($urandom_range(1, 12));
		r.year = encode($urandom_range(0, 99));
		if (h24_mode) begin
			r.hour = encode(hr);
		end else begin
			h12 = (hr % 12 == 0) ? 12 : hr % 12;
			r.hour = encode(h12) | ((hr >= 12) ? 8'h80 : 8'h00);
		end
		case ($urandom_range(0, 5))
			0: r.century = encode(19);
			1: r.century = encode(20);
			2: r.century = encode(21);
			3: r.century = 8'h00;
			4: r.century = 8'hFF;
			default: r.century = 8'($urandom);
		endcase
		if ($urandom_range(0, 3) == 0) begin
			k = $urandom_range(0, 6);
			r[8 * k +: 8] = 8'($urandom);
		end
		return r;
	endfunction

	// Second read that differs from the first in one byte.
	function automatic raw_regs_t corrupt(raw_regs_t r);
		int         k;
		logic [7:0] x;
		k = $urandom_range(0, 6);
		x = 8'($urandom_range(1, 255));
		return r ^ (56'(x) << (8 * k));
	endfunction

	// Present one word and wait for the accepting edge; push stays high.
	task automatic send_word(snapshot_t s);
		push <= 1'b1;
		snapshot <= s;
		do begin
			@(posedge clk);
			if (full)
				full_stalls++;
		end while (full);
		items_sent++;
		predict_decode(s);
	endtask

	// Bursts of random length, then a random gap with push low.
	task automatic pace();
		int gap;
		if (!pacing_on)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
		push <= 1'b0;
		repeat (gap) @(posedge clk);
		// every so often a long gap-free stretch
		burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) :
			$urandom_range(0, 12);
	endtask

	task automatic offer(snapshot_t s);
		send_word(s);
		pace();
	endtask

	task automatic send_pair(raw_regs_t a, raw_regs_t b);
		offer(snap_of(a, 1'b0));
		offer(snap_of(b, 1'b0));
	endtask

	// Wait until every due word has come out, then wait out the drain period
	// before touching config; any lone first snapshot stays held in the front.
	task automatic wait_idle();
		push <= 1'b0;
		while (decoded_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// cfg_valid stays high between back-to-back writes
	task automatic write_reg(logic idx, logic val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_BINARY_MODE)
			bin_mode = val;
		else
			h24_mode = val;
	endtask

	task automatic set_modes(bit bin, bit h24);
		wait_idle();
		write_reg(REG_BINARY_MODE, bin);
		write_reg(REG_HOUR24_MODE, h24);
		cfg_valid <= 1'b0;
		mode_phases++;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// All-zero and all-ones registers: month 0 and BCD garbage both
	// come back implausible, century clamps to 20.
	task automatic test_field_extremes();
		send_pair(regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
			regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_pair(regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
			regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
	endtask

	// Last second of 1969 gives zero seconds; 31 February just rolls over.
	task automatic test_calendar_edges();
		send_pair(regs(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69, 8'h19),
			regs(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69, 8'h19));
		send_pair(regs(8'h00, 8'h00, 8'h12, 8'h31, 8'h02, 8'h24, 8'h20),
			regs(8'h00, 8'h00, 8'h12, 8'h31, 8'h02, 8'h24, 8'h20));
	endtask

	// Timeout flag on a first read, then on a second read.
	task automatic test_uip_timeout();
		raw_regs_t r;
		r = regs(8'h30, 8'h15, 8'h08, 8'h14, 8'h07, 8'h25, 8'h20);
		offer(snap_of(r, 1'b1));
		offer(snap_of(r, 1'b0));
		offer(snap_of(r, 1'b1));
	endtask

	// Reads that never agree: exactly PAIR_RETRIES failed pairs.
	task automatic test_retry_exhaustion();
		raw_regs_t r;
		r = regs(8'h45, 8'h59, 8'h23, 8'h28, 8'h02, 8'h99, 8'h20);
		repeat (PAIR_RETRIES)
			send_pair(r, corrupt(r));
	endtask

	// Random traffic under the current modes: mostly agreeing pairs, plus
	// mismatches, retry storms, timeouts and lone noise words that shift
	// the pairing.
	task automatic test_random_traffic(int n_items);
		int        sent, pick, k;
		raw_regs_t a, b;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			a = random_regs();
			if (pick < 60) begin
				send_pair(a, a);
				sent += 2;
			end else if (pick < 72) begin
				send_pair(a, corrupt(a));
				sent += 2;
			end else if (pick < 80) begin
				// around the retry limit, then a pair that agrees
				k = $urandom_range(PAIR_RETRIES - 3, PAIR_RETRIES + 2);
				repeat (k) begin
					b = random_regs();
					send_pair(b, corrupt(b));
				end
				send_pair(a, a);
				sent += 2 * k + 2;
			end else if (pick < 90) begin
				if ($urandom_range(0, 1)) begin
					offer(snap_of(a, 1'b1));
					sent += 1;
				end else begin
					offer(snap_of(a, 1'b0));
					offer(snap_of(a, 1'b1));
					sent += 2;
				end
			end else begin
				a = 56'({$urandom, $urandom});
				offer(snap_of(a, $urandom_range(0, 7) == 0));
				sent += 1;
			end
		end
	endtask

	// Reader holds off while agreeing pairs stream in back to back, so the
	// result and job queues fill and full must hold the sender.
	task automatic test_backpressure();
		raw_regs_t r;
		pacing_on = 1'b0;
		hold_request = 400;
		repeat (40) begin
			r = random_regs();
			send_pair(r, r);
		end
		pacing_on = 1'b1;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset modes: BCD, 24-hour
		test_field_extremes();
		test_calendar_edges();
		test_uip_timeout();
		test_retry_exhaustion();

		set_modes(1'b0, 1'b0);
		test_random_traffic(190);
		set_modes(1'b1, 1'b1);
		test_random_traffic(190);
		test_backpressure();
		set_modes(1'b1, 1'b0);
		test_random_traffic(190);
		set_modes(1'b0, 1'b1);
		test_random_traffic(190);

		wait_idle();
		$display("sent %0d snapshots over %0d mode settings; %0d words checked",
			items_sent, mode_phases + 1, words_checked);
		$display("status ok/timeout/no-agree/implausible: %0d/%0d/%0d/%0d; %0d full stalls",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3],
			full_stalls);
		if (bad_words == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[rtc_snapshot_time_decoder.f]
rtl/rsd_pkg.sv
rtl/rsd_fifo.sv
rtl/rsd_front.sv
rtl/rsd_back.sv
rtl/rtc_snapshot_time_decoder.sv
rtl/rsd_checker.sv
test/rtc_snapshot_time_decoder_tb.sv
